// ----- src/sfms_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sfms_pkg;

  // pattern window geometry
  localparam int unsigned PAT_MAX   = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PAT_BITS  = PAT_MAX * BYTE_W;
  localparam int unsigned LEN_W     = $clog2(PAT_MAX + 1);
  localparam int unsigned LEN_REG_W = 6;

  // haystack offsets
  localparam int unsigned OFFSET_W = 16;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

  // configuration port
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PAT_WORDS = 4;

  // front to back queue geometry, depth a power of two
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_WORD_0 = 3'd0,
    CFG_PAT_WORD_1 = 3'd1,
    CFG_PAT_WORD_2 = 3'd2,
    CFG_PAT_WORD_3 = 3'd3,
    CFG_PAT_LENGTH = 3'd4,
    CFG_START_OFS  = 3'd5
  } cfg_idx_e;

  // live configuration
  typedef struct packed {
    logic [PAT_BITS-1:0]  pattern;
    logic [LEN_REG_W-1:0] length;
    logic [OFFSET_W-1:0]  start;
  } cfg_t;

  // one classified byte travelling from front to back
  typedef struct packed {
    logic [BYTE_W-1:0]   data_byte;
    logic                last_byte;
    logic                cand;
    logic                len_zero;
    logic                was_sat;
    logic [LEN_W-1:0]    len;
    logic [OFFSET_W-1:0] offset;
  } item_t;

  // queue handshake between front and back
  typedef struct packed {
    logic  push;
    item_t item;
  } q_push_t;

  typedef struct packed {
    logic  valid;
    logic  full;
    item_t item;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- src/sfms_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// haystack byte channel
interface sfms_in_if;
  import sfms_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// search result channel
interface sfms_out_if;
  import sfms_pkg::*;
  logic                valid;
  logic                ready;
  logic                found;
  logic [OFFSET_W-1:0] match_offset;
  logic                too_long;

  modport source (output valid, output found, output match_offset, output too_long,
                  input ready);
  modport sink   (input valid, input found, input match_offset, input too_long,
                  output ready);
endinterface

`default_nettype wire

// ----- src/sfms_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfms_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire sfms_pkg::cfg_t  cfg_i,
  sfms_in_if.sink              in_if,
  input  wire sfms_pkg::q_stat_t q_stat_i,
  output sfms_pkg::q_push_t    q_push_o
);
  import sfms_pkg::*;

  logic [OFFSET_W-1:0] pos_q, pos_d;
  logic                sat_q, sat_d;
  logic                accept;
  logic [LEN_W-1:0]    len;
  logic [OFFSET_W:0]   end_pos;
  logic [OFFSET_W:0]   begin_pos;
  logic                fits;
  item_t               item;

  assign in_if.ready = !q_stat_i.full;
  assign accept      = in_if.valid && !q_stat_i.full;

  // clamp the pattern length to the window size
  always_comb begin
    if (cfg_i.length > LEN_REG_W'(PAT_MAX)) begin
      len = LEN_W'(PAT_MAX);
    end else begin
      len = LEN_W'(cfg_i.length);
    end
  end

  // candidate match that ends on this byte
  assign end_pos   = {1'b0, pos_q} + (OFFSET_W+1)'(1);
  assign begin_pos = end_pos - (OFFSET_W+1)'(len);
  assign fits      = (end_pos >= (OFFSET_W+1)'(len)) &&
                     (begin_pos >= {1'b0, cfg_i.start});

  always_comb begin
    item.data_byte = in_if.data_byte;
    item.last_byte = in_if.last_byte;
    item.len_zero  = (len == '0);
    item.was_sat   = sat_q;
    item.len       = len;
    if (len == '0) begin
      item.cand   = !sat_q && (pos_q == '0);
      item.offset = cfg_i.start;
    end else begin
      item.cand   = !sat_q && fits;
      item.offset = begin_pos[OFFSET_W-1:0];
    end
  end

  assign q_push_o.push = accept;
  assign q_push_o.item = item;

  // position counter with saturation, cleared at end of haystack
  always_comb begin
    pos_d = pos_q;
    sat_d = sat_q;
    if (accept) begin
      if (in_if.last_byte) begin
        pos_d = '0;
        sat_d = 1'b0;
      end else if (!sat_q) begin
        if (pos_q == OFFSET_MAX) begin
          sat_d = 1'b1;
        end else begin
          pos_d = pos_q + OFFSET_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sat_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      sat_q <= sat_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/sfms_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfms_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sfms_pkg::q_push_t q_push_i,
  input  wire logic              pop_i,
  output sfms_pkg::q_stat_t      q_stat_o
);
  import sfms_pkg::*;

  item_t              ent_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  assign q_stat_o.valid = (cnt_q != '0);
  assign q_stat_o.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign q_stat_o.item  = ent_q[rd_ptr_q];

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (q_push_i.push && !do_pop) begin
      cnt_d = cnt_q + Q_CNT_W'(1);
    end else if (!q_push_i.push && do_pop) begin
      cnt_d = cnt_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (q_push_i.push) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (q_push_i.push) begin
      ent_q[wr_ptr_q] <= q_push_i.item;
    end
  end

endmodule

`default_nettype wire

// ----- src/sfms_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfms_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sfms_pkg::cfg_t    cfg_i,
  input  wire sfms_pkg::q_stat_t q_stat_i,
  output logic                   pop_o,
  sfms_out_if.source             out_if
);
  import sfms_pkg::*;

  logic [PAT_BITS-1:0] win_q;
  logic [PAT_BITS-1:0] win_next;
  logic [PAT_BITS-1:0] pat_rev;
  logic [PAT_BITS-1:0] pat_aligned;
  logic [LEN_W-1:0]    shift_bytes;
  logic [PAT_MAX-1:0]  byte_ok;
  logic                reported_q;
  logic                hit;
  logic                miss;
  logic                emit;
  item_t               it;

  logic                out_valid_q;
  logic                found_q;
  logic [OFFSET_W-1:0] offset_q;
  logic                too_long_q;

  assign it    = q_stat_i.item;
  assign pop_o = q_stat_i.valid && (!out_valid_q || out_if.ready);

  // newest byte enters at byte 0
  assign win_next = {win_q[PAT_BITS-BYTE_W-1:0], it.data_byte};

  // pattern reversed so byte i of the window lines up with pattern byte len-1-i
  always_comb begin
    for (int j = 0; j < PAT_MAX; j++) begin
      pat_rev[j*BYTE_W +: BYTE_W] = cfg_i.pattern[(PAT_MAX-1-j)*BYTE_W +: BYTE_W];
    end
  end

  assign shift_bytes = LEN_W'(PAT_MAX) - it.len;
  assign pat_aligned = pat_rev >> ({3'b000, shift_bytes} * (LEN_W+3)'(BYTE_W));

  // parallel byte compare over the active part of the window
  always_comb begin
    for (int i = 0; i < PAT_MAX; i++) begin
      byte_ok[i] = (LEN_W'(i) >= it.len) ||
                   (win_next[i*BYTE_W +: BYTE_W] == pat_aligned[i*BYTE_W +: BYTE_W]);
    end
  end

  assign hit  = it.cand && !reported_q && (it.len_zero || (&byte_ok));
  assign miss = it.last_byte && !reported_q && !hit;
  assign emit = hit || miss;

  // window shift
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      win_q <= win_next;
    end
  end

  // per-haystack result bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reported_q <= 1'b0;
    end else if (pop_o) begin
      if (it.last_byte) begin
        reported_q <= 1'b0;
      end else if (hit) begin
        reported_q <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      found_q    <= hit;
      offset_q   <= hit ? it.offset : '0;
      too_long_q <= hit ? 1'b0 : it.was_sat;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.found        = found_q;
  assign out_if.match_offset = offset_q;
  assign out_if.too_long     = too_long_q;

endmodule

`default_nettype wire

// ----- src/substring_first_match_search_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Streaming first-match substring search. Haystack bytes are taken one per
// clock while the queue has room; the block reports the lowest offset at
// or after start_offset where the pattern (up to 32 bytes, set by
// pattern_length) lies wholly in the haystack, with one result transaction
// per haystack: at the first match or, with found clear, on the last byte.
// A zero-length pattern reports start_offset on the first byte. Offsets
// saturate at 65535 and later bytes never match; too_long then marks the
// not-found result. Throughput is one byte per cycle while the output is
// not stalled, set by the combinational window compare in the back end;
// the front classifies each byte combinationally into the two-entry queue,
// and the back compare loads the output register when it pops the entry.
// Write the configuration registers only while no bytes are in flight.
module substring_first_match_search_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [sfms_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [sfms_pkg::CFG_W-1:0]     cfg_data_i,
  sfms_in_if.sink                             in_if,
  sfms_out_if.source                          out_if
);
  import sfms_pkg::*;

  cfg_t    cfg_q;
  q_push_t q_push;
  q_stat_t q_stat;
  logic    pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PAT_WORD_0: cfg_q.pattern[0*CFG_W +: CFG_W] <= cfg_data_i;
        CFG_PAT_WORD_1: cfg_q.pattern[1*CFG_W +: CFG_W] <= cfg_data_i;
        CFG_PAT_WORD_2: cfg_q.pattern[2*CFG_W +: CFG_W] <= cfg_data_i;
        CFG_PAT_WORD_3: cfg_q.pattern[3*CFG_W +: CFG_W] <= cfg_data_i;
        CFG_PAT_LENGTH: cfg_q.length <= cfg_data_i[LEN_REG_W-1:0];
        CFG_START_OFS:  cfg_q.start  <= cfg_data_i[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  sfms_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_if    (in_if),
    .q_stat_i (q_stat),
    .q_push_o (q_push)
  );

  sfms_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_push_i (q_push),
    .pop_i    (pop),
    .q_stat_o (q_stat)
  );

  sfms_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_if   (out_if)
  );

endmodule

`default_nettype wire
